>>> src/rtd_divider_linearizer_macros.svh
// Assertion macros shared by the RTD linearizer RTL.
`ifndef RTD_DIVIDER_LINEARIZER_MACROS_SVH
`define RTD_DIVIDER_LINEARIZER_MACROS_SVH

// Same-cycle implication, checked on clk and disabled during reset.
`define RTD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk and disabled during reset.
`define RTD_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/rtd_pkg.sv
// Types, constants and the Pt1000 breakpoint table of the RTD linearizer.
package rtd_pkg;

	localparam int TABLE_POINTS = 24;
	localparam int IDX_W        = $clog2(TABLE_POINTS);

	localparam int UV_W    = 23;
	localparam int OHM_W   = 16;
	localparam int HOLD_W  = 16;
	localparam int TIME_W  = 32;
	localparam int TEMP_W  = 16;
	localparam int RT_W    = 15;   // table resistance, tenths of an ohm
	localparam int DR_W    = 9;    // resistance step of one segment
	localparam int DT_W    = 10;   // temperature step of one segment
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 16;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int N_W     = 43;   // 10 * series * (supply - pin)
	localparam int REM_W   = 32;   // offset into segment, scaled by pin
	localparam int DEN_W   = 32;   // pin * segment step
	localparam int QUOT_W  = 11;   // fraction of segment step, at most 1000
	localparam int CNT_W   = $clog2(QUOT_W + 1);

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_SUPPLY_UV   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SERIES_OHM  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF_MS  = 2'd2;

	localparam logic [UV_W-1:0]   SUPPLY_UV_RST  = 23'd3300000;
	localparam logic [OHM_W-1:0]  SERIES_OHM_RST = 16'd1000;
	localparam logic [HOLD_W-1:0] HOLDOFF_RST    = 16'd5000;

	localparam logic signed [TEMP_W-1:0] FAULT_TEMP_CENTI = -16'sd30000;
	localparam logic signed [TEMP_W-1:0] TEMP_MIN_CENTI   = -16'sd4000;
	localparam logic signed [TEMP_W-1:0] TEMP_MAX_CENTI   = 16'sd18000;

	typedef struct packed {
		logic              done;
		logic [QUOT_W-1:0] quot;
		logic              rem_nz;
	} div_res_t;

	function automatic logic [RT_W-1:0] ohm_tenths_at(input logic [IDX_W-1:0] idx);
		logic [RT_W-1:0] r;
		case (idx)
			5'd0:    r = 15'd8427;
			5'd1:    r = 15'd8822;
			5'd2:    r = 15'd9216;
			5'd3:    r = 15'd9609;
			5'd4:    r = 15'd10000;
			5'd5:    r = 15'd10390;
			5'd6:    r = 15'd10779;
			5'd7:    r = 15'd10974;
			5'd8:    r = 15'd11167;
			5'd9:    r = 15'd11554;
			5'd10:   r = 15'd11940;
			5'd11:   r = 15'd12324;
			5'd12:   r = 15'd12700;
			5'd13:   r = 15'd13089;
			5'd14:   r = 15'd13470;
			5'd15:   r = 15'd13850;
			5'd16:   r = 15'd14220;
			5'd17:   r = 15'd14606;
			5'd18:   r = 15'd14982;
			5'd19:   r = 15'd15358;
			5'd20:   r = 15'd15731;
			5'd21:   r = 15'd16000;
			5'd22:   r = 15'd16400;
			5'd23:   r = 15'd16800;
			default: r = 15'd16800;
		endcase
		return r;
	endfunction

	function automatic logic signed [TEMP_W-1:0] temp_centi_at(input logic [IDX_W-1:0] idx);
		logic signed [TEMP_W-1:0] t;
		case (idx)
			5'd0:    t = -16'sd4000;
			5'd1:    t = -16'sd3000;
			5'd2:    t = -16'sd2000;
			5'd3:    t = -16'sd1000;
			5'd4:    t = 16'sd0;
			5'd5:    t = 16'sd1000;
			5'd6:    t = 16'sd2000;
			5'd7:    t = 16'sd2500;
			5'd8:    t = 16'sd3000;
			5'd9:    t = 16'sd4000;
			5'd10:   t = 16'sd5000;
			5'd11:   t = 16'sd6000;
			5'd12:   t = 16'sd7000;
			5'd13:   t = 16'sd8000;
			5'd14:   t = 16'sd9000;
			5'd15:   t = 16'sd10000;
			5'd16:   t = 16'sd11000;
			5'd17:   t = 16'sd12000;
			5'd18:   t = 16'sd13000;
			5'd19:   t = 16'sd14000;
			5'd20:   t = 16'sd15000;
			5'd21:   t = 16'sd16000;
			5'd22:   t = 16'sd17000;
			5'd23:   t = 16'sd18000;
			default: t = 16'sd18000;
		endcase
		return t;
	endfunction

endpackage

>>> src/rtd_mul.sv
// Shared registered multiplier used for every product of the linearizer.
module rtd_mul (
	input  logic                         clk,
	input  logic                         en,
	input  logic [rtd_pkg::MUL_A_W-1:0]  a,
	input  logic [rtd_pkg::MUL_B_W-1:0]  b,
	output logic [rtd_pkg::PROD_W-1:0]   prod
);

	logic [rtd_pkg::PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end

	assign prod = prod_q;

endmodule

>>> src/rtd_div.sv
// Restoring divider, one quotient bit per cycle, for the segment fraction.
module rtd_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [rtd_pkg::N_W-1:0]     dividend,
	input  logic [rtd_pkg::DEN_W-1:0]   divisor,
	output rtd_pkg::div_res_t           res
);

	logic [rtd_pkg::N_W-1:0]    rem_q;
	logic [rtd_pkg::N_W-1:0]    dsr_q;
	logic [rtd_pkg::QUOT_W-1:0] quot_q;
	logic [rtd_pkg::CNT_W-1:0]  cnt_q;
	logic                       done_q;
	logic                       ge;

	assign ge = (rem_q >= dsr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			rem_q  <= dividend;
			dsr_q  <= rtd_pkg::N_W'(divisor) << (rtd_pkg::QUOT_W - 1);
			quot_q <= '0;
			cnt_q  <= rtd_pkg::CNT_W'(rtd_pkg::QUOT_W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			// subtract the shifted divisor where it fits, shift in the bit
			if (ge) begin
				rem_q <= rem_q - dsr_q;
			end
			quot_q <= {quot_q[rtd_pkg::QUOT_W-2:0], ge};
			dsr_q  <= dsr_q >> 1;
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == rtd_pkg::CNT_W'(1));
		end else begin
			done_q <= 1'b0;
		end
	end

	assign res.done   = done_q;
	assign res.quot   = quot_q;
	assign res.rem_nz = |rem_q;

endmodule

>>> src/rtd_divider_linearizer.sv
// Top level of the Pt1000 divider linearizer: sequencer, registers and output stage.
// Usage:
// - Input channel (in_valid/in_stall, pin_uv, time_ms): one sample per item. in_stall
//   is high while an item is being worked on; one item is in flight at a time.
// - Output channel (out_valid/out_stall, temp_centi, fault): zero or one result per
//   item, held in an output register until the receiver drops out_stall.
// - Configuration (cfg_we, cfg_index, cfg_data): write supply, series resistor and
//   holdoff only while the block is idle; unknown indexes are ignored.
// Datapath: one registered 32x16 multiplier is shared by every product and a
// restoring divider yields one quotient bit per cycle. The segment search walks the
// breakpoints, with a multiply and then a compare for each, and stops at the first
// one above the resistance or at the last segment. An in-range item passes through
// setup, the breakpoint search, the segment steps, the divider and the output step.
// Out of range (including zero pin voltage) starts the fault timer; no result is
// given until the holdoff has elapsed, then -300.00 degC with fault set.
// Reset restores the register defaults, clears the fault timer and empties the
// output register. When the receiver stalls, a finished result waits in the output
// stage and the next item's result waits in the sequencer until it drains.
`include "rtd_divider_linearizer_macros.svh"

module rtd_divider_linearizer (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [rtd_pkg::UV_W-1:0]              pin_uv,
	input  logic [rtd_pkg::TIME_W-1:0]            time_ms,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic signed [rtd_pkg::TEMP_W-1:0]     temp_centi,
	output logic                                  fault,
	input  logic                                  cfg_we,
	input  logic [rtd_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [rtd_pkg::UV_W-1:0]              cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_N,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_CHK_HI,
		ST_SRCH_MUL,
		ST_SRCH_CMP,
		ST_SEG,
		ST_REM,
		ST_DEN,
		ST_DIVGO,
		ST_DIV,
		ST_OOR,
		ST_OUT
	} state_t;

	localparam logic [rtd_pkg::IDX_W-1:0] IDX_FIRST = rtd_pkg::IDX_W'(0);
	localparam logic [rtd_pkg::IDX_W-1:0] IDX_LAST  = rtd_pkg::IDX_W'(rtd_pkg::TABLE_POINTS - 1);
	localparam logic [rtd_pkg::IDX_W-1:0] SEG_LAST  = rtd_pkg::IDX_W'(rtd_pkg::TABLE_POINTS - 2);

	state_t state_q;

	// configuration registers
	logic [rtd_pkg::UV_W-1:0]   supply_q;
	logic [rtd_pkg::OHM_W-1:0]  series_q;
	logic [rtd_pkg::HOLD_W-1:0] holdoff_q;

	// fault timer
	logic                        fault_pending_q;
	logic [rtd_pkg::TIME_W-1:0]  fault_start_q;

	// working registers of the current item
	logic [rtd_pkg::UV_W-1:0]   p_q;
	logic [rtd_pkg::TIME_W-1:0] now_q;
	logic [rtd_pkg::N_W-1:0]    n_q;
	logic                       lo_fail_q;
	logic [rtd_pkg::IDX_W-1:0]  i_q;
	logic [rtd_pkg::IDX_W-1:0]  k_q;
	logic [rtd_pkg::REM_W-1:0]  rem_q;
	logic [rtd_pkg::DEN_W-1:0]  den_q;
	logic [rtd_pkg::TEMP_W-1:0] res_temp_q;
	logic                       res_fault_q;

	// output stage
	logic                       out_valid_q;
	logic [rtd_pkg::TEMP_W-1:0] out_temp_q;
	logic                       out_fault_q;

	// shared multiplier
	logic                        mul_en;
	logic [rtd_pkg::MUL_A_W-1:0] mul_a;
	logic [rtd_pkg::MUL_B_W-1:0] mul_b;
	logic [rtd_pkg::PROD_W-1:0]  prod;

	// divider
	logic                        div_start;
	rtd_pkg::div_res_t           div_res;

	// segment data and derived values
	logic [rtd_pkg::IDX_W-1:0]         k_next;
	logic [rtd_pkg::RT_W-1:0]          dr_full;
	logic [rtd_pkg::DR_W-1:0]          dr;
	logic [rtd_pkg::TEMP_W-1:0]        dt_full;
	logic [rtd_pkg::DT_W-1:0]          dt;
	logic [rtd_pkg::UV_W-1:0]          v_diff;
	logic [rtd_pkg::N_W-1:0]           n_calc;
	logic [rtd_pkg::PROD_W-1:0]        n_wide;
	logic [rtd_pkg::N_W-1:0]           rem_diff;
	logic [rtd_pkg::TEMP_W-1:0]        t_base;
	logic                              t_corr;
	logic [rtd_pkg::TEMP_W:0]          t_sum;
	logic [rtd_pkg::TIME_W-1:0]        elapsed;

	assign k_next  = k_q + 1'b1;
	assign dr_full = rtd_pkg::ohm_tenths_at(k_next) - rtd_pkg::ohm_tenths_at(k_q);
	assign dr      = dr_full[rtd_pkg::DR_W-1:0];
	assign dt_full = rtd_pkg::temp_centi_at(k_next) - rtd_pkg::temp_centi_at(k_q);
	assign dt      = dt_full[rtd_pkg::DT_W-1:0];
	assign v_diff  = supply_q - p_q;

	// N = 10 * series * (supply - pin) as (m << 3) + (m << 1)
	assign n_calc = {1'b0, prod[38:0], 3'b000} + {3'b000, prod[38:0], 1'b0};
	assign n_wide = {{(rtd_pkg::PROD_W - rtd_pkg::N_W){1'b0}}, n_q};

	assign rem_diff = n_q - prod[rtd_pkg::N_W-1:0];

	// truncate toward zero: a negative base with a remainder rounds the fraction up
	assign t_base = rtd_pkg::temp_centi_at(k_q);
	assign t_corr = t_base[rtd_pkg::TEMP_W-1] & div_res.rem_nz;
	assign t_sum  = {t_base[rtd_pkg::TEMP_W-1], t_base}
		+ {{(rtd_pkg::TEMP_W + 1 - rtd_pkg::QUOT_W){1'b0}}, div_res.quot}
		+ {{rtd_pkg::TEMP_W{1'b0}}, t_corr};

	// elapsed time since the fault started, modulo 2^32; zero on the first miss
	assign elapsed = now_q - (fault_pending_q ? fault_start_q : now_q);

	always_comb begin
		mul_en    = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		case (state_q)
			ST_MUL_N: begin
				mul_en = 1'b1;
				mul_a  = {{(rtd_pkg::MUL_A_W - rtd_pkg::UV_W){1'b0}}, v_diff};
				mul_b  = series_q;
			end
			ST_MUL_LO: begin
				mul_en = 1'b1;
				mul_a  = {{(rtd_pkg::MUL_A_W - rtd_pkg::UV_W){1'b0}}, p_q};
				mul_b  = {1'b0, rtd_pkg::ohm_tenths_at(IDX_FIRST)};
			end
			ST_MUL_HI: begin
				mul_en = 1'b1;
				mul_a  = {{(rtd_pkg::MUL_A_W - rtd_pkg::UV_W){1'b0}}, p_q};
				mul_b  = {1'b0, rtd_pkg::ohm_tenths_at(IDX_LAST)};
			end
			ST_SRCH_MUL: begin
				mul_en = 1'b1;
				mul_a  = {{(rtd_pkg::MUL_A_W - rtd_pkg::UV_W){1'b0}}, p_q};
				mul_b  = {1'b0, rtd_pkg::ohm_tenths_at(i_q)};
			end
			ST_SEG: begin
				mul_en = 1'b1;
				mul_a  = {{(rtd_pkg::MUL_A_W - rtd_pkg::UV_W){1'b0}}, p_q};
				mul_b  = {1'b0, rtd_pkg::ohm_tenths_at(k_q)};
			end
			ST_REM: begin
				mul_en = 1'b1;
				mul_a  = {{(rtd_pkg::MUL_A_W - rtd_pkg::UV_W){1'b0}}, p_q};
				mul_b  = {{(rtd_pkg::MUL_B_W - rtd_pkg::DR_W){1'b0}}, dr};
			end
			ST_DEN: begin
				mul_en = 1'b1;
				mul_a  = rem_q;
				mul_b  = {{(rtd_pkg::MUL_B_W - rtd_pkg::DT_W){1'b0}}, dt};
			end
			ST_DIVGO: begin
				div_start = 1'b1;
			end
			default: begin
			end
		endcase
	end

	rtd_mul u_mul (
		.clk  (clk),
		.en   (mul_en),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	rtd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod[rtd_pkg::N_W-1:0]),
		.divisor  (den_q),
		.res      (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			supply_q        <= rtd_pkg::SUPPLY_UV_RST;
			series_q        <= rtd_pkg::SERIES_OHM_RST;
			holdoff_q       <= rtd_pkg::HOLDOFF_RST;
			fault_pending_q <= 1'b0;
			fault_start_q   <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					rtd_pkg::REG_SUPPLY_UV:  supply_q  <= cfg_data;
					rtd_pkg::REG_SERIES_OHM: series_q  <= cfg_data[rtd_pkg::OHM_W-1:0];
					rtd_pkg::REG_HOLDOFF_MS: holdoff_q <= cfg_data[rtd_pkg::HOLD_W-1:0];
					default: begin
					end
				endcase
			end

			// load a finished result once the output register is free,
			// drop the output item once the receiver takes it
			if (state_q == ST_OUT && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						p_q     <= pin_uv;
						now_q   <= time_ms;
						state_q <= ST_MUL_N;
					end
				end
				ST_MUL_N: begin
					// zero pin voltage or pin above supply: no valid resistance
					if (p_q == '0 || p_q > supply_q) begin
						state_q <= ST_OOR;
					end else begin
						state_q <= ST_MUL_LO;
					end
				end
				ST_MUL_LO: begin
					n_q     <= n_calc;
					state_q <= ST_MUL_HI;
				end
				ST_MUL_HI: begin
					lo_fail_q <= (n_wide < prod);
					state_q   <= ST_CHK_HI;
				end
				ST_CHK_HI: begin
					if (lo_fail_q || n_wide > prod) begin
						state_q <= ST_OOR;
					end else begin
						k_q     <= IDX_FIRST;
						i_q     <= rtd_pkg::IDX_W'(1);
						state_q <= (rtd_pkg::TABLE_POINTS > 2) ? ST_SRCH_MUL : ST_SEG;
					end
				end
				ST_SRCH_MUL: begin
					state_q <= ST_SRCH_CMP;
				end
				ST_SRCH_CMP: begin
					// breakpoints rise, so stop at the first one above the resistance
					if (prod > n_wide) begin
						state_q <= ST_SEG;
					end else begin
						k_q <= i_q;
						if (i_q == SEG_LAST) begin
							state_q <= ST_SEG;
						end else begin
							i_q     <= i_q + 1'b1;
							state_q <= ST_SRCH_MUL;
						end
					end
				end
				ST_SEG: begin
					state_q <= ST_REM;
				end
				ST_REM: begin
					rem_q   <= rem_diff[rtd_pkg::REM_W-1:0];
					state_q <= ST_DEN;
				end
				ST_DEN: begin
					den_q   <= prod[rtd_pkg::DEN_W-1:0];
					state_q <= ST_DIVGO;
				end
				ST_DIVGO: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_res.done) begin
						res_temp_q      <= t_sum[rtd_pkg::TEMP_W-1:0];
						res_fault_q     <= 1'b0;
						fault_pending_q <= 1'b0;
						state_q         <= ST_OUT;
					end
				end
				ST_OOR: begin
					if (!fault_pending_q) begin
						fault_pending_q <= 1'b1;
						fault_start_q   <= now_q;
					end
					if (elapsed < {{(rtd_pkg::TIME_W - rtd_pkg::HOLD_W){1'b0}}, holdoff_q}) begin
						state_q <= ST_IDLE;
					end else begin
						res_temp_q  <= rtd_pkg::FAULT_TEMP_CENTI;
						res_fault_q <= 1'b1;
						state_q     <= ST_OUT;
					end
				end
				ST_OUT: begin
					// hold the result until the output register is free
					if (!out_valid_q || !out_stall) begin
						out_temp_q  <= res_temp_q;
						out_fault_q <= res_fault_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall   = (state_q != ST_IDLE);
	assign out_valid  = out_valid_q;
	assign temp_centi = out_temp_q;
	assign fault      = out_fault_q;

	`RTD_ASSERT_IMP(a_fault_temp, out_valid && fault, temp_centi == rtd_pkg::FAULT_TEMP_CENTI, "fault result without fault temperature")
	`RTD_ASSERT_IMP(a_temp_range, out_valid && !fault, temp_centi >= rtd_pkg::TEMP_MIN_CENTI && temp_centi <= rtd_pkg::TEMP_MAX_CENTI, "interpolated temperature outside table")
	`RTD_ASSERT_NXT(a_div_to_out, state_q == ST_DIV && div_res.done, state_q == ST_OUT && !fault_pending_q, "divider result not taken to output")

endmodule
